FILE: rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Types and constants shared by the frame receiver checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

  // Frame delimiters, as 16-bit little-endian words.
  localparam logic [15:0] HEAD_WORD = 16'h55AA;
  localparam logic [15:0] TAIL_WORD = 16'hEEFF;

  // Verdict codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_HEAD = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_BAD_SUM  = 3'd3;
  localparam logic [2:0] ST_BAD_TAIL = 3'd4;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [3:0] {
    PH_HEAD0     = 4'd0,
    PH_HEAD1     = 4'd1,
    PH_ID0       = 4'd2,
    PH_ID1       = 4'd3,
    PH_CMD       = 4'd4,
    PH_LEN0      = 4'd5,
    PH_LEN1      = 4'd6,
    PH_PAYLOAD   = 4'd7,
    PH_CHECK     = 4'd8,
    PH_TAIL0     = 4'd9,
    PH_TAIL1     = 4'd10,
    PH_SKIP      = 4'd11,
    PH_HEAD1_BAD = 4'd12
  } phase_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [2:0]  status;
    logic [15:0] frame_id;
    logic [7:0]  command;
    logic [15:0] payload_length;
  } frc_result_t;

endpackage

`default_nettype wire

FILE: rtl/frc_in_if.sv
// ----------------------------------------------------------------------------
// frc_in_if
// Byte channel into the frame receiver checker.
// ----------------------------------------------------------------------------
`default_nettype none

interface frc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       datagram_end;

  modport source (output valid, output rx_byte, output datagram_end, input ready);
  modport sink   (input valid, input rx_byte, input datagram_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/frc_out_if.sv
// ----------------------------------------------------------------------------
// frc_out_if
// Result channel out of the frame receiver checker.
// ----------------------------------------------------------------------------
`default_nettype none

interface frc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [2:0]  status;
  logic [15:0] frame_id;
  logic [7:0]  command;
  logic [15:0] payload_length;

  modport source (
    output valid, output result_kind, output payload_byte, output payload_index,
    output status, output frame_id, output command, output payload_length,
    input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input payload_index,
    input status, input frame_id, input command, input payload_length,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/frame_receiver_checker_unit.sv
// An accepted item is held in the input register and its result in the result register.
// Throughput: one input item per cycle unless a result stalls; the parser state updates in one step.
// The input register and the result register let a new item enter while a
// result waits; a stalled result holds only the item behind it.
// Reset (rst_n low, synchronous) empties both registers and rearms the head
// search with all held frame fields cleared.
// ----------------------------------------------------------------------------
// frame_receiver_checker_unit
// Checks the frame at the start of each datagram, passes payload bytes on and
// reports one verdict per datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_receiver_checker_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  frc_in_if.sink    in_ch,
  frc_out_if.source out_ch
);
  import frc_pkg::*;

  logic        item_valid;
  logic [7:0]  item_byte;
  logic        item_end;
  logic        can_load;
  logic        step;
  logic        res_valid;
  frc_result_t res;

  // An item is processed only when the result register can take its result.
  assign step = item_valid && can_load;

  frc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (step),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_end   (item_end)
  );

  frc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item_byte (item_byte),
    .item_end  (item_end),
    .res_valid (res_valid),
    .res       (res)
  );

  frc_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_valid),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/frc_in_stage.sv
// ----------------------------------------------------------------------------
// frc_in_stage
// Input register: holds one received item until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_in_stage (
  input  wire logic   clk,
  input  wire logic   rst_n,
  frc_in_if.sink      in_ch,
  input  wire logic   advance,
  output logic        item_valid,
  output logic [7:0]  item_byte,
  output logic        item_end
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       end_r;
  logic       take;

  // A new item may enter when the register is empty or drains this cycle.
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_ch.rx_byte;
      end_r  <= in_ch.datagram_end;
    end
  end

  assign item_valid = valid_r;
  assign item_byte  = byte_r;
  assign item_end   = end_r;

endmodule

`default_nettype wire

FILE: rtl/frc_core.sv
// ----------------------------------------------------------------------------
// frc_core
// Frame parser: phase machine, running checksum and held header fields.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [7:0]           item_byte,
  input  wire logic                 item_end,
  output logic                      res_valid,
  output frc_pkg::frc_result_t      res
);
  import frc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] id_r, id_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic        sum_bad_r, sum_bad_nxt;
  logic        tail_bad_r, tail_bad_nxt;

  logic        verdict_v;
  logic [2:0]  verdict_code;
  logic        have_payload;
  logic [16:0] count_inc;
  logic [15:0] len_full;

  assign count_inc = {1'b0, count_r} + 17'd1;
  assign len_full  = {item_byte, len_r[7:0]};

  // Next state.
  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    id_nxt       = id_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    sum_bad_nxt  = sum_bad_r;
    tail_bad_nxt = tail_bad_r;
    if (step) begin
      case (phase_r)
        PH_HEAD0: begin
          count_nxt    = '0;
          sum_nxt      = '0;
          id_nxt       = '0;
          cmd_nxt      = '0;
          len_nxt      = '0;
          sum_bad_nxt  = 1'b0;
          tail_bad_nxt = 1'b0;
          phase_nxt    = (item_byte == HEAD_WORD[7:0]) ? PH_HEAD1 : PH_HEAD1_BAD;
        end
        PH_HEAD1: begin
          phase_nxt = (item_byte != HEAD_WORD[15:8]) ? PH_SKIP : PH_ID0;
        end
        PH_HEAD1_BAD: begin
          phase_nxt = PH_SKIP;
        end
        PH_ID0: begin
          id_nxt    = {8'h00, item_byte};
          sum_nxt   = sum_r + item_byte;
          phase_nxt = PH_ID1;
        end
        PH_ID1: begin
          id_nxt    = {item_byte, id_r[7:0]};
          sum_nxt   = sum_r + item_byte;
          phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          cmd_nxt   = item_byte;
          sum_nxt   = sum_r + item_byte;
          phase_nxt = PH_LEN0;
        end
        PH_LEN0: begin
          len_nxt   = {8'h00, item_byte};
          sum_nxt   = sum_r + item_byte;
          phase_nxt = PH_LEN1;
        end
        PH_LEN1: begin
          len_nxt   = len_full;
          sum_nxt   = sum_r + item_byte;
          count_nxt = '0;
          phase_nxt = (len_full != 16'h0000) ? PH_PAYLOAD : PH_CHECK;
        end
        PH_PAYLOAD: begin
          sum_nxt   = sum_r + item_byte;
          count_nxt = count_inc[15:0];
          if (count_inc >= {1'b0, len_r}) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          sum_bad_nxt = (item_byte != sum_r);
          phase_nxt   = PH_TAIL0;
        end
        PH_TAIL0: begin
          tail_bad_nxt = (item_byte != TAIL_WORD[7:0]);
          phase_nxt    = PH_TAIL1;
        end
        PH_TAIL1: begin
          if (item_byte != TAIL_WORD[15:8]) begin
            tail_bad_nxt = 1'b1;
          end
          phase_nxt = PH_SKIP;
        end
        default: begin
          phase_nxt = PH_SKIP;
        end
      endcase
      // The end flag always rearms the head search.
      if (item_end) begin
        phase_nxt = PH_HEAD0;
      end
    end
  end

  // Outputs.
  always_comb begin
    verdict_v    = 1'b0;
    verdict_code = ST_OK;
    have_payload = 1'b0;
    case (phase_r)
      PH_HEAD0: begin
        if (item_end) begin
          verdict_v    = 1'b1;
          verdict_code = ST_BAD_HEAD;
        end
      end
      PH_HEAD1: begin
        if (item_byte != HEAD_WORD[15:8]) begin
          verdict_v    = 1'b1;
          verdict_code = ST_BAD_HEAD;
        end
      end
      PH_HEAD1_BAD: begin
        verdict_v    = 1'b1;
        verdict_code = ST_BAD_HEAD;
      end
      PH_PAYLOAD: begin
        have_payload = 1'b1;
      end
      PH_TAIL1: begin
        verdict_v = 1'b1;
        if (sum_bad_r) begin
          verdict_code = ST_BAD_SUM;
        end else if (tail_bad_r || (item_byte != TAIL_WORD[15:8])) begin
          verdict_code = ST_BAD_TAIL;
        end else begin
          verdict_code = ST_OK;
        end
      end
      default: begin
        verdict_v = 1'b0;
      end
    endcase
    // A datagram that stops inside the frame after a good first head byte.
    if (item_end && !verdict_v && (phase_r inside {[PH_HEAD1:PH_TAIL0]})) begin
      verdict_v    = 1'b1;
      verdict_code = ST_SHORT;
    end

    res_valid          = step && (verdict_v || have_payload);
    res.result_kind    = verdict_v ? KIND_VERDICT : KIND_PAYLOAD;
    res.payload_byte   = verdict_v ? 8'h00 : item_byte;
    res.payload_index  = verdict_v ? 16'h0000 : count_r;
    res.status         = verdict_v ? verdict_code : ST_OK;
    res.frame_id       = id_nxt;
    res.command        = cmd_nxt;
    res.payload_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEAD0;
      count_r    <= '0;
      sum_r      <= '0;
      id_r       <= '0;
      cmd_r      <= '0;
      len_r      <= '0;
      sum_bad_r  <= 1'b0;
      tail_bad_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      id_r       <= id_nxt;
      cmd_r      <= cmd_nxt;
      len_r      <= len_nxt;
      sum_bad_r  <= sum_bad_nxt;
      tail_bad_r <= tail_bad_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    step && item_end |=> phase_r == PH_HEAD0)
    else $error("end of datagram did not rearm the head search");

  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.result_kind == KIND_PAYLOAD) |-> phase_r == PH_PAYLOAD)
    else $error("payload item outside the payload phase");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> count_r < len_r)
    else $error("payload index reached the length field");

  a_bad_head_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_HEAD1_BAD) |-> res_valid && (res.status == ST_BAD_HEAD))
    else $error("bad first head byte gave no bad head verdict");
`endif

endmodule

`default_nettype wire

FILE: rtl/frc_out_stage.sv
// ----------------------------------------------------------------------------
// frc_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire frc_pkg::frc_result_t res,
  output logic                      can_load,
  frc_out_if.source                 out_ch
);
  import frc_pkg::*;

  logic        valid_r, valid_nxt;
  frc_result_t res_r;

  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.result_kind    = res_r.result_kind;
  assign out_ch.payload_byte   = res_r.payload_byte;
  assign out_ch.payload_index  = res_r.payload_index;
  assign out_ch.status         = res_r.status;
  assign out_ch.frame_id       = res_r.frame_id;
  assign out_ch.command        = res_r.command;
  assign out_ch.payload_length = res_r.payload_length;

endmodule

`default_nettype wire

FILE: sim/frc_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_stream_checker
// Watches both channels of the frame receiver checker, runs its own frame
// parser on every accepted byte and compares each accepted result with the
// oldest predicted one. Mismatches and unexpected results are counted.
// ----------------------------------------------------------------------------
module frc_stream_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  frc_in_if                 in_ch,
  frc_out_if                out_ch,
  output int unsigned       mismatch_count,
  output int unsigned       results_pending
);
  import frc_pkg::*;

  phase_t      ph;
  logic [15:0] pl_count;
  logic [7:0]  sum_acc;
  logic [15:0] id_r;
  logic [7:0]  command_r;
  logic [15:0] length_r;
  logic        sum_bad_r;
  logic        tail_bad_r;

  frc_result_t expected_results[$];
  int unsigned fails = 0;

  assign mismatch_count = fails;

  function automatic void clear_frame_fields();
    pl_count   = '0;
    sum_acc    = '0;
    id_r       = '0;
    command_r  = '0;
    length_r   = '0;
    sum_bad_r  = 1'b0;
    tail_bad_r = 1'b0;
  endfunction

  // Advances the parser by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output frc_result_t res);
    phase_t      prior;
    bit          has_verdict;
    logic [2:0]  verdict;
    bit          has_payload;
    logic [15:0] pidx;
    prior       = ph;
    has_verdict = 1'b0;
    verdict     = ST_OK;
    has_payload = 1'b0;
    pidx        = '0;
    res         = '0;
    case (prior)
      PH_HEAD0: begin
        clear_frame_fields();
        ph = (b == HEAD_WORD[7:0]) ? PH_HEAD1 : PH_HEAD1_BAD;
        if (last) begin
          has_verdict = 1'b1;
          verdict     = ST_BAD_HEAD;
        end
      end
      PH_HEAD1: begin
        if (b != HEAD_WORD[15:8]) begin
          has_verdict = 1'b1;
          verdict     = ST_BAD_HEAD;
          ph          = PH_SKIP;
        end else begin
          ph = PH_ID0;
        end
      end
      PH_HEAD1_BAD: begin
        has_verdict = 1'b1;
        verdict     = ST_BAD_HEAD;
        ph          = PH_SKIP;
      end
      PH_ID0: begin
        id_r    = {8'h00, b};
        sum_acc = sum_acc + b;
        ph      = PH_ID1;
      end
      PH_ID1: begin
        id_r[15:8] = b;
        sum_acc    = sum_acc + b;
        ph         = PH_CMD;
      end
      PH_CMD: begin
        command_r = b;
        sum_acc   = sum_acc + b;
        ph        = PH_LEN0;
      end
      PH_LEN0: begin
        length_r = {8'h00, b};
        sum_acc  = sum_acc + b;
        ph       = PH_LEN1;
      end
      PH_LEN1: begin
        length_r[15:8] = b;
        sum_acc        = sum_acc + b;
        pl_count       = '0;
        ph             = (length_r != 16'd0) ? PH_PAYLOAD : PH_CHECK;
      end
      PH_PAYLOAD: begin
        sum_acc     = sum_acc + b;
        has_payload = 1'b1;
        pidx        = pl_count;
        if ({1'b0, pl_count} + 17'd1 >= {1'b0, length_r}) ph = PH_CHECK;
        pl_count = pl_count + 16'd1;
      end
      PH_CHECK: begin
        sum_bad_r = (b != sum_acc);
        ph        = PH_TAIL0;
      end
      PH_TAIL0: begin
        tail_bad_r = (b != TAIL_WORD[7:0]);
        ph         = PH_TAIL1;
      end
      PH_TAIL1: begin
        if (b != TAIL_WORD[15:8]) tail_bad_r = 1'b1;
        has_verdict = 1'b1;
        verdict     = sum_bad_r ? ST_BAD_SUM : (tail_bad_r ? ST_BAD_TAIL : ST_OK);
        ph          = PH_SKIP;
      end
      default: ph = PH_SKIP;
    endcase

    // An early end inside the frame overrides any payload result of this byte.
    if (last) begin
      if (!has_verdict && prior != PH_SKIP && prior <= PH_TAIL0) begin
        has_verdict = 1'b1;
        verdict     = ST_SHORT;
      end
      ph = PH_HEAD0;
    end

    res.frame_id       = id_r;
    res.command        = command_r;
    res.payload_length = length_r;
    if (has_verdict) begin
      res.result_kind = KIND_VERDICT;
      res.status      = verdict;
      return 1'b1;
    end
    if (has_payload) begin
      res.result_kind   = KIND_PAYLOAD;
      res.payload_byte  = b;
      res.payload_index = pidx;
      res.status        = ST_OK;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    frc_result_t pred;
    frc_result_t want;
    frc_result_t got;
    if (!rst_n) begin
      ph = PH_HEAD0;
      clear_frame_fields();
      expected_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.rx_byte, in_ch.datagram_end, pred))
          expected_results.push_back(pred);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{result_kind: out_ch.result_kind, payload_byte: out_ch.payload_byte,
                payload_index: out_ch.payload_index, status: out_ch.status,
                frame_id: out_ch.frame_id, command: out_ch.command,
                payload_length: out_ch.payload_length};
        if (expected_results.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected result kind=%0d byte=%02h index=%0d status=%0d",
                     $realtime, got.result_kind, got.payload_byte, got.payload_index,
                     got.status);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fails < 10) begin
              $display("%0t: mismatch expected kind=%0d byte=%02h index=%0d status=%0d",
                       $realtime, want.result_kind, want.payload_byte,
                       want.payload_index, want.status);
              $display("    expected id=%04h cmd=%02h len=%04h", want.frame_id,
                       want.command, want.payload_length);
              $display("    actual   kind=%0d byte=%02h index=%0d status=%0d",
                       got.result_kind, got.payload_byte, got.payload_index,
                       got.status);
              $display("    actual   id=%04h cmd=%02h len=%04h", got.frame_id,
                       got.command, got.payload_length);
            end
            fails++;
          end
        end
      end
    end
    results_pending = expected_results.size();
  end

endmodule

FILE: sim/frame_receiver_checker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_receiver_checker_unit_tb
// Feeds datagrams into the frame receiver checker: a few hand-built cases,
// then random frames that are mostly well formed, with bad sums, bad tails,
// bad heads, early ends and noise mixed in. Both channels stall at random, but not in the last random stage.
// ----------------------------------------------------------------------------
module frame_receiver_checker_unit_tb;
  import frc_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned RANDOM_ITEMS = 750;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count;
  int unsigned results_pending;
  logic [7:0]  dgram[$];

  frc_in_if  in_ch ();
  frc_out_if out_ch ();

  frame_receiver_checker_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frc_stream_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Starts and ends at a falling edge; the last byte carries the end flag.
  task automatic send_dgram();
    for (int i = 0; i < dgram.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid        <= 1'b0;
        in_ch.rx_byte      <= 8'($urandom);
        in_ch.datagram_end <= 1'($urandom);
        @(negedge clk);
      end
      in_ch.valid        <= 1'b1;
      in_ch.rx_byte      <= dgram[i];
      in_ch.datagram_end <= (i == dgram.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      @(negedge clk);
      bytes_sent++;
    end
    dgram.delete();
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic put_frame(input logic [15:0] id, input logic [7:0] cmd,
                           input int unsigned len, input bit bad_sum, input bit bad_tail);
    logic [7:0]  sum;
    logic [7:0]  pb;
    logic [15:0] len16;
    int unsigned which;
    len16 = len[15:0];
    sum   = id[7:0] + id[15:8] + cmd + len16[7:0] + len16[15:8];
    dgram.push_back(HEAD_WORD[7:0]);
    dgram.push_back(HEAD_WORD[15:8]);
    dgram.push_back(id[7:0]);
    dgram.push_back(id[15:8]);
    dgram.push_back(cmd);
    dgram.push_back(len16[7:0]);
    dgram.push_back(len16[15:8]);
    for (int i = 0; i < len; i++) begin
      pb  = 8'($urandom);
      sum = sum + pb;
      dgram.push_back(pb);
    end
    dgram.push_back(bad_sum ? sum ^ 8'($urandom_range(255, 1)) : sum);
    which = $urandom_range(2);
    dgram.push_back((bad_tail && which != 1) ? TAIL_WORD[7:0] ^ 8'($urandom_range(255, 1))
                                             : TAIL_WORD[7:0]);
    dgram.push_back((bad_tail && which != 0) ? TAIL_WORD[15:8] ^ 8'($urandom_range(255, 1))
                                             : TAIL_WORD[15:8]);
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(6, 1);
    if (r < 95) return $urandom_range(40, 7);
    return $urandom_range(300, 100);
  endfunction

  task automatic make_random_dgram();
    int unsigned r;
    int unsigned cut;
    int unsigned n;
    logic [7:0]  b0;
    r = $urandom_range(99);
    if (r < 74) begin
      put_frame(16'($urandom), 8'($urandom), pick_length(),
                (r >= 55 && r < 63) || r >= 71, r >= 63);
      if (r < 55 && $urandom_range(2) == 0) begin
        n = $urandom_range(3, 1);
        repeat (n) dgram.push_back(8'($urandom));
      end
    end else if (r < 80) begin
      // Either head byte wrong, then some junk up to the end flag.
      b0 = 8'($urandom);
      dgram.push_back(b0);
      if (b0 == HEAD_WORD[7:0])
        dgram.push_back(HEAD_WORD[15:8] ^ 8'($urandom_range(255, 1)));
      else
        dgram.push_back(8'($urandom));
      n = $urandom_range(5);
      repeat (n) dgram.push_back(8'($urandom));
    end else if (r < 92) begin
      put_frame(16'($urandom), 8'($urandom), pick_length(), 1'b0, 1'b0);
      cut = $urandom_range(dgram.size() - 1, 1);
      while (dgram.size() > cut) void'(dgram.pop_back());
    end else begin
      n = $urandom_range(6, 1);
      dgram.push_back($urandom_range(1) ? HEAD_WORD[7:0] : 8'($urandom));
      repeat (n - 1) dgram.push_back(8'($urandom));
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.rx_byte      = 8'h00;
    in_ch.datagram_end = 1'b0;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 27;
    recv_idle_pct      = 79;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // One-byte datagrams: wrong first byte, and a head cut after its first byte.
    dgram = '{8'h00};
    send_dgram();
    dgram = '{HEAD_WORD[7:0]};
    send_dgram();
    // Wrong second head byte, then a good head with nothing after it.
    dgram = '{HEAD_WORD[7:0], 8'h00};
    send_dgram();
    dgram = '{HEAD_WORD[7:0], HEAD_WORD[15:8]};
    send_dgram();
    // Empty payload goes straight to the checksum.
    put_frame(16'h0000, 8'h00, 0, 1'b0, 1'b0);
    send_dgram();
    // All-ones fields, ending on the first payload byte.
    dgram = '{HEAD_WORD[7:0], HEAD_WORD[15:8], 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_dgram();
    drain_results();

    for (int stage = 0; stage < 3; stage++) begin
      send_idle_pct = (stage == 0) ? 27 : (stage == 1) ? 79 : 0;
      recv_idle_pct = (stage == 0) ? 79 : (stage == 1) ? 27 : 0;
      while (bytes_sent < 24 + (stage + 1) * (RANDOM_ITEMS / 3)) begin
        make_random_dgram();
        send_dgram();
      end
      // Hold the sender until the block has delivered everything owed.
      drain_results();
    end

    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/frc_pkg.sv
rtl/frc_in_if.sv
rtl/frc_out_if.sv
rtl/frc_in_stage.sv
rtl/frc_core.sv
rtl/frc_out_stage.sv
rtl/frame_receiver_checker_unit.sv
sim/frc_stream_checker.sv
sim/frame_receiver_checker_unit_tb.sv
